[src/sdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types, sizes and the hash function of the duplicate filter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned ValueW = 32;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StProbe = 2'b10
  } state_e;

  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    value_t wr_data;
    logic   clear;
  } tbl_cmd_t;

  typedef struct packed {
    logic   hit_valid;
    value_t data;
  } tbl_rsp_t;

  // Fold the word onto the index width, then bring it into table range.
  function automatic idx_t hash_idx(value_t v);
    logic [IdxW-1:0] h;
    int unsigned j;
    h = '0;
    j = 0;
    for (int unsigned i = 0; i < ValueW; i++) begin
      h[j] = h[j] ^ v[i];
      j = (j == IdxW - 1) ? 0 : j + 1;
    end
    if ({1'b0, h} >= (IdxW+1)'(TableEntries)) begin
      h = IdxW'({1'b0, h} - (IdxW+1)'(TableEntries));
    end
    return h;
  endfunction

endpackage

[src/sdf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_in_if / sdf_out_if
// Valid/ready channels for input words and filter results.
// ----------------------------------------------------------------------------
interface sdf_in_if;
  logic            valid;
  logic            ready;
  sdf_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface sdf_out_if;
  logic            valid;
  logic            ready;
  sdf_pkg::value_t value_out;
  logic            keep;
  logic            last_out;
  logic            overflow;

  modport source (output valid, output value_out, output keep, output last_out,
                  output overflow, input ready);
  modport sink (input valid, input value_out, input keep, input last_out,
                input overflow, output ready);
endinterface

[src/stream_duplicate_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_duplicate_filter
// Per-sequence duplicate removal over a stream of signed 32-bit words.
// ----------------------------------------------------------------------------
// One result word per input word: the value, keep (first occurrence in the
// current sequence), last and overflow (new value, table full, not stored).
// Seen values sit in a hash table of sdf_pkg::TableEntries slots with linear
// probing. The first table read is issued in the accept cycle; each further
// probe then reads the next slot on the single memory read port. A word needs
// one probe when the home slot is empty or holds the value, and up to
// TableEntries probes for a new value while the table is full. Output
// backpressure holds a word longer. All valid flags clear together when the
// result of a last word is registered; no clearing pass.
// ----------------------------------------------------------------------------
module stream_duplicate_filter (
  input logic      clk_i,
  input logic      rst_ni,
  sdf_in_if.sink   in_i,
  sdf_out_if.source out_o
);

  sdf_pkg::state_e   state_q, state_d;
  sdf_pkg::value_t   val_q, val_d;
  logic              last_q, last_d;
  sdf_pkg::idx_t     addr_q, addr_d;
  sdf_pkg::idx_t     probe_q, probe_d;

  logic              out_valid_q, out_valid_d;
  sdf_pkg::value_t   out_value_q, out_value_d;
  logic              out_keep_q, out_keep_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;

  sdf_pkg::tbl_cmd_t cmd;
  sdf_pkg::tbl_rsp_t rsp;

  logic          accept;
  logic          hit, empty, exhausted, done, out_free;
  sdf_pkg::idx_t next_addr;

  sdf_seen_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  assign in_i.ready = (state_q == sdf_pkg::StIdle);
  assign accept     = in_i.valid && in_i.ready;

  assign hit       = rsp.hit_valid && (rsp.data == val_q);
  assign empty     = !rsp.hit_valid;
  assign exhausted = !hit && !empty &&
                     (probe_q == sdf_pkg::idx_t'(sdf_pkg::TableEntries - 1));
  assign done      = hit || empty || exhausted;
  assign out_free  = !out_valid_q || out_o.ready;
  assign next_addr = (addr_q == sdf_pkg::idx_t'(sdf_pkg::TableEntries - 1)) ?
                     '0 : addr_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    last_d      = last_q;
    addr_d      = addr_q;
    probe_d     = probe_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_value_d = out_value_q;
    out_keep_d  = out_keep_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    cmd         = '0;
    cmd.wr_addr = addr_q;
    cmd.wr_data = val_q;
    cmd.rd_addr = sdf_pkg::hash_idx(in_i.value);

    case (state_q)
      sdf_pkg::StIdle: begin
        if (accept) begin
          cmd.rd_en = 1'b1;
          val_d     = in_i.value;
          last_d    = in_i.last;
          addr_d    = cmd.rd_addr;
          probe_d   = '0;
          state_d   = sdf_pkg::StProbe;
        end
      end
      sdf_pkg::StProbe: begin
        if (!done) begin
          // advance to the next slot
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = next_addr;
          addr_d      = next_addr;
          probe_d     = probe_q + 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = val_q;
          out_keep_d  = !hit;
          out_last_d  = last_q;
          out_ovf_d   = exhausted;
          cmd.wr_en   = empty;
          cmd.clear   = last_q;
          state_d     = sdf_pkg::StIdle;
        end
      end
      default: begin
        state_d = sdf_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdf_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    last_q      <= last_d;
    addr_q      <= addr_d;
    probe_q     <= probe_d;
    out_value_q <= out_value_d;
    out_keep_q  <= out_keep_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = out_value_q;
  assign out_o.keep      = out_keep_q;
  assign out_o.last_out  = out_last_q;
  assign out_o.overflow  = out_ovf_q;

endmodule

[src/sdf_seen_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_seen_table
// Value memory with registered read data and per-entry valid flags.
// ----------------------------------------------------------------------------
module sdf_seen_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdf_pkg::tbl_cmd_t cmd_i,
  output sdf_pkg::tbl_rsp_t rsp_o
);

  sdf_pkg::value_t mem [sdf_pkg::TableEntries];
  logic [sdf_pkg::TableEntries-1:0] valid_q;
  sdf_pkg::value_t rd_data_q;
  logic rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[cmd_i.wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[cmd_i.rd_addr];
      end
    end
  end

  assign rsp_o.hit_valid = rd_valid_q;
  assign rsp_o.data      = rd_data_q;

endmodule
